/* rtl/core/sght_pkg.sv */
// ----------------------------------------------------------------------------
// sght_pkg - shared types and constants of the spatial grid hash table
// Operation and status codes, controller states and the command / status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sght_pkg;

  // Configuration register and bus
  localparam int CFG_W            = 11;
  localparam int BUCKET_COUNT_RST = 1024;
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;
  localparam logic REG_BUCKET_COUNT = 1'b0;

  // Payload widths
  localparam int HANDLE_W = 16;

  // Hash coefficients
  localparam int HASH_KX = 541;
  localparam int HASH_KY = 79;
  localparam int HASH_KZ = 31;

  // Remainder unit: four quotient bits per cycle over a 32-bit magnitude
  localparam int MAG_W     = 32;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = MAG_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W     = CFG_W + 1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_DIV,
    S_FILL,
    S_DECIDE,
    S_RD,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    clr_wr;
    logic    capture;
    logic    hash;
    logic    div_step;
    logic    fill_rd;
    logic    way_clr;
    logic    way_inc;
    logic    ent_rd;
    logic    ent_rd_next;
    logic    ins_wr;
    logic    shift_wr;
    logic    fill_dec;
    logic    res_set;
    status_e res_code;
    logic    res_handle;
    logic    out_load;
  } sght_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic is_insert;
    logic is_remove;
    logic fill_full;
    logic way_lt_fill;
    logic next_lt_fill;
    logic hit;
    logic out_free;
  } sght_sts_t;

endpackage

/* rtl/core/sght_if.sv */
// ----------------------------------------------------------------------------
// sght_if - request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface sght_in_if #(
  parameter int COORD_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic [15:0]                 cell_handle;

  modport source (output valid, mode, coord_x, coord_y, coord_z, cell_handle,
                  input ready);
  modport sink   (input valid, mode, coord_x, coord_y, coord_z, cell_handle,
                  output ready);
endinterface

interface sght_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_handle;

  modport source (output valid, status, found_handle, input ready);
  modport sink   (input valid, status, found_handle, output ready);
endinterface

/* rtl/core/spatial_grid_hash_table_top.sv */
// ----------------------------------------------------------------------------
// spatial_grid_hash_table_top - chained hash table of 3D grid cells
// After reset the block clears the fill count of every bucket and holds
// req_i.ready low meanwhile. Requests are then served one at a time: an
// insert passes through a hash step, the radix-16 remainder unit, a
// fill-count read, a decision and an output load; a lookup or remove also
// reads and compares each way scanned through the single entry-memory port,
// a remove also reads and writes every later entry to shift it down, and a
// closing state either ends a scan that misses or updates the fill count
// after a remove. The next request is accepted while a response waits.
// ----------------------------------------------------------------------------
module spatial_grid_hash_table_top #(
  parameter int NUM_BUCKETS = 1024,
  parameter int WAYS        = 4,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sght_in_if.sink                       req_i,
  sght_out_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sght_pkg::APB_AW-1:0]   paddr,
  input  logic [sght_pkg::APB_DW-1:0]   pwdata,
  output logic [sght_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import sght_pkg::*;

  sght_cmd_t cmd;
  sght_sts_t sts;

  // Bucket count register
  logic [CFG_W-1:0] bucket_count_q;
  logic             reg_sel;

  assign reg_sel = (paddr[APB_AW-1:2] == REG_BUCKET_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DW'(bucket_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= CFG_W'(BUCKET_COUNT_RST);
    end else if (psel && penable && pwrite && reg_sel) begin
      bucket_count_q <= pwdata[CFG_W-1:0];
    end
  end

  sght_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sght_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .bucket_count_i (bucket_count_q),
    .mode_i         (req_i.mode),
    .coord_x_i      (req_i.coord_x),
    .coord_y_i      (req_i.coord_y),
    .coord_z_i      (req_i.coord_z),
    .cell_handle_i  (req_i.cell_handle),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .found_handle_o (rsp_o.found_handle)
  );

`ifndef SYNTHESIS
  // A new word is never taken in the cycle after one was accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while previous one in flight");

  // Memory write sources never collide
  a_write_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_wr, cmd.ins_wr, cmd.shift_wr, cmd.fill_dec}))
    else $error("conflicting memory writes");

  // A returned handle only comes with a successful status
  a_handle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.found_handle != '0) |-> rsp_o.status == ST_OK)
    else $error("handle returned with failing status");
`endif

endmodule

/* rtl/core/sght_ctrl.sv */
// ----------------------------------------------------------------------------
// sght_ctrl - request sequencer
// Walks each request through hash, remainder, bucket read, way scan and
// remove shift, and steps the fill-count clearing pass after reset.
// ----------------------------------------------------------------------------
module sght_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output sght_pkg::sght_cmd_t cmd_o,
  input  sght_pkg::sght_sts_t sts_i
);
  import sght_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FILL;
      end
      S_FILL: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.res_set = 1'b1;
        if (sts_i.is_insert) begin
          state_d = S_DONE;
          if (sts_i.fill_full) begin
            cmd_o.res_code = ST_FULL;
          end else begin
            cmd_o.res_code = ST_OK;
            cmd_o.ins_wr   = 1'b1;
          end
        end else begin
          cmd_o.res_code = ST_NOT_FOUND;
          cmd_o.way_clr  = 1'b1;
          state_d        = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.way_lt_fill) begin
          cmd_o.ent_rd = 1'b1;
          state_d      = S_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_code   = ST_OK;
          cmd_o.res_handle = !sts_i.is_remove;
          state_d          = sts_i.is_remove ? S_SHRD : S_DONE;
        end else begin
          cmd_o.way_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_SHRD: begin
        if (sts_i.next_lt_fill) begin
          cmd_o.ent_rd_next = 1'b1;
          state_d           = S_SHWR;
        end else begin
          cmd_o.fill_dec = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.way_inc  = 1'b1;
        state_d        = S_SHRD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/sght_dp.sv */
// ----------------------------------------------------------------------------
// sght_dp - hash table datapath
// Request registers, hash, radix-16 remainder unit, fill-count and entry
// memories, way counter, result and output registers.
// ----------------------------------------------------------------------------
module sght_dp #(
  parameter int NUM_BUCKETS = 1024,
  parameter int WAYS        = 4,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sght_pkg::sght_cmd_t           cmd_i,
  output sght_pkg::sght_sts_t           sts_o,
  input  logic [sght_pkg::CFG_W-1:0]    bucket_count_i,
  input  logic [1:0]                    mode_i,
  input  logic signed [COORD_BITS-1:0]  coord_x_i,
  input  logic signed [COORD_BITS-1:0]  coord_y_i,
  input  logic signed [COORD_BITS-1:0]  coord_z_i,
  input  logic [sght_pkg::HANDLE_W-1:0] cell_handle_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [sght_pkg::HANDLE_W-1:0] found_handle_o
);
  import sght_pkg::*;

  localparam int BKT_W = $clog2(NUM_BUCKETS);
  localparam int FW    = $clog2(WAYS + 1);
  localparam int AW    = $clog2(NUM_BUCKETS * WAYS);
  localparam int KEY_W = 3 * COORD_BITS;
  localparam int ENT_W = KEY_W + HANDLE_W;

  // Request word
  logic [1:0]                   mode_q;
  logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
  logic [HANDLE_W-1:0]          handle_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      x_q      <= coord_x_i;
      y_q      <= coord_y_i;
      z_q      <= coord_z_i;
      handle_q <= cell_handle_i;
    end
  end

  // Effective modulus: zero acts as one, clamp to the bucket array
  logic [CFG_W-1:0] modulus;
  always_comb begin
    if (bucket_count_i == '0) begin
      modulus = CFG_W'(1);
    end else if (32'(bucket_count_i) > 32'(NUM_BUCKETS)) begin
      modulus = CFG_W'(NUM_BUCKETS);
    end else begin
      modulus = bucket_count_i;
    end
  end

  // Hash magnitude
  logic signed [MAG_W-1:0] sx, sy, sz, hsum;
  logic [MAG_W-1:0]        mag;
  always_comb begin
    sx   = MAG_W'(x_q);
    sy   = MAG_W'(y_q);
    sz   = MAG_W'(z_q);
    hsum = MAG_W'(sx * HASH_KX + sy * HASH_KY + sz * HASH_KZ);
    mag  = hsum[MAG_W-1] ? MAG_W'(-hsum) : MAG_W'(hsum);
  end

  // Remainder unit, four restoring steps a cycle
  logic [MAG_W-1:0]     mag_q, mag_nx;
  logic [REM_W-1:0]     rem_q, rem_nx;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  always_comb begin
    rem_nx = rem_q;
    mag_nx = mag_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      rem_nx = {rem_nx[REM_W-2:0], mag_nx[MAG_W-1]};
      mag_nx = {mag_nx[MAG_W-2:0], 1'b0};
      if (rem_nx >= REM_W'(modulus)) rem_nx = rem_nx - REM_W'(modulus);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash) begin
      mag_q <= mag;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      mag_q <= mag_nx;
      rem_q <= rem_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.hash) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  logic [BKT_W-1:0] bkt;
  assign bkt = BKT_W'(rem_q);

  // Clearing pass over the fill counts
  logic [BKT_W-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Fill-count memory
  logic [FW-1:0]    fill_mem [NUM_BUCKETS];
  logic [FW-1:0]    fill_rd_q, fill_c, fill_wd;
  logic [BKT_W-1:0] fill_wa;
  logic             fill_we;

  assign fill_c  = (fill_rd_q > FW'(WAYS)) ? FW'(WAYS) : fill_rd_q;
  assign fill_we = cmd_i.clr_wr | cmd_i.ins_wr | cmd_i.fill_dec;
  assign fill_wa = cmd_i.clr_wr ? clr_q : bkt;

  always_comb begin
    if (cmd_i.clr_wr) begin
      fill_wd = '0;
    end else if (cmd_i.ins_wr) begin
      fill_wd = FW'(fill_c + 1'b1);
    end else begin
      fill_wd = FW'(fill_c - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (cmd_i.fill_rd) fill_rd_q <= fill_mem[bkt];
  end

  // Way counter
  logic [FW-1:0] way_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_q <= '0;
    end else if (cmd_i.way_clr) begin
      way_q <= '0;
    end else if (cmd_i.way_inc) begin
      way_q <= way_q + 1'b1;
    end
  end

  // Entry memory, one row of WAYS entries per bucket
  logic [ENT_W-1:0] ent_mem [NUM_BUCKETS * WAYS];
  logic [ENT_W-1:0] ent_rdata_q, ent_wd;
  logic [FW-1:0]    way_sel;
  logic [AW-1:0]    ent_addr;

  always_comb begin
    if (cmd_i.ins_wr) begin
      way_sel = fill_c;
    end else if (cmd_i.ent_rd_next) begin
      way_sel = FW'(way_q + 1'b1);
    end else begin
      way_sel = way_q;
    end
    ent_addr = AW'(AW'(bkt) * AW'(WAYS) + AW'(way_sel));
    ent_wd   = cmd_i.ins_wr ? {handle_q, z_q, y_q, x_q} : ent_rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr | cmd_i.shift_wr) ent_mem[ent_addr] <= ent_wd;
    if (cmd_i.ent_rd | cmd_i.ent_rd_next) ent_rdata_q <= ent_mem[ent_addr];
  end

  // Result of the current request
  logic [1:0]          res_status_q;
  logic [HANDLE_W-1:0] res_handle_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_handle_q <= cmd_i.res_handle ? ent_rdata_q[ENT_W-1 -: HANDLE_W] : '0;
    end
  end

  // Output register, reloaded only once the previous word is taken
  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [HANDLE_W-1:0] out_handle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_handle_o = out_handle_q;

  // Status to the controller
  always_comb begin
    sts_o.clr_last     = (clr_q == BKT_W'(NUM_BUCKETS - 1));
    sts_o.div_last     = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
    sts_o.is_insert    = (mode_q == MODE_INSERT);
    sts_o.is_remove    = (mode_q == MODE_REMOVE);
    sts_o.fill_full    = (fill_c >= FW'(WAYS));
    sts_o.way_lt_fill  = (way_q < fill_c);
    sts_o.next_lt_fill = ((FW+1)'(way_q) + 1'b1) < (FW+1)'(fill_c);
    sts_o.hit          = (ent_rdata_q[KEY_W-1:0] == {z_q, y_q, x_q});
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

endmodule

/* sim/sght_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sght_checker - response predictor and scoreboard for the grid hash table
// Watches the request and response channels and keeps its own copy of the
// bucket store and the bucket count. Each accepted request word is run
// through the table model and yields one expected response word. Each
// accepted response word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module sght_checker #(
  parameter int NUM_BUCKETS = 1024,
  parameter int WAYS        = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sght_in_if.sink     req_mon,
  sght_out_if.sink    rsp_mon,
  input  logic        cfg_wr_i,
  input  logic [10:0] cfg_val_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  import sght_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [15:0] handle;
  } rsp_word_t;

  logic [63:0] cell_mem [NUM_BUCKETS][WAYS];
  int          cell_fill [NUM_BUCKETS];
  logic [10:0] modulus;
  rsp_word_t   rsp_q [$];

  assign pending_o = rsp_q.size();

  // Bucket of a key under the current modulus
  function automatic int bucket_of(logic signed [15:0] x, logic signed [15:0] y,
                                   logic signed [15:0] z);
    longint s;
    longint m;
    m = modulus;
    if (m == 0) m = 1;
    if (m > NUM_BUCKETS) m = NUM_BUCKETS;
    s = 541 * longint'(x) + 79 * longint'(y) + 31 * longint'(z);
    if (s < 0) s = -s;
    return int'(s % m);
  endfunction

  // Apply one request word to the table and return its response word
  function automatic rsp_word_t apply_request(logic [1:0] mode, logic [15:0] x,
                                              logic [15:0] y, logic [15:0] z,
                                              logic [15:0] hdl);
    rsp_word_t   r;
    int          b;
    int          f;
    int          hit;
    logic [47:0] key;
    r.status = ST_NOT_FOUND;
    r.handle = '0;
    b   = bucket_of(x, y, z);
    f   = cell_fill[b];
    key = {z, y, x};
    hit = -1;
    if (mode == MODE_INSERT) begin
      if (f >= WAYS) begin
        r.status = ST_FULL;
      end else begin
        cell_mem[b][f] = {hdl, key};
        cell_fill[b]   = f + 1;
        r.status       = ST_OK;
      end
      return r;
    end
    for (int i = 0; i < f; i++) begin
      if (hit < 0 && cell_mem[b][i][47:0] == key) hit = i;
    end
    if (hit < 0) return r;
    r.status = ST_OK;
    if (mode == MODE_REMOVE) begin
      for (int i = hit; i + 1 < f; i++) cell_mem[b][i] = cell_mem[b][i+1];
      cell_fill[b] = f - 1;
    end else begin
      r.handle = cell_mem[b][hit][63:48];
    end
    return r;
  endfunction

  // Predict on accepted requests, compare on accepted responses
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_word_t exp_w;
    rsp_word_t new_w;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
      modulus    = 11'd1024;
      rsp_q.delete();
      foreach (cell_fill[i]) cell_fill[i] = 0;
    end else begin
      if (cfg_wr_i) modulus = cfg_val_i;
      if (req_mon.valid && req_mon.ready) begin
        new_w = apply_request(req_mon.mode, req_mon.coord_x, req_mon.coord_y,
                              req_mon.coord_z, req_mon.cell_handle);
        rsp_q = {rsp_q, new_w};
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (rsp_q.size() == 0) begin
          $error("response word with nothing expected");
          errs++;
        end else begin
          exp_w = rsp_q.pop_front();
          if (rsp_mon.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, rsp_mon.status);
            errs++;
          end
          if (rsp_mon.found_handle !== exp_w.handle) begin
            $error("found_handle: expected %h, got %h", exp_w.handle,
                   rsp_mon.found_handle);
            errs++;
          end
        end
      end
      fail_cnt_o <= fail_cnt_o + errs;
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the spatial grid hash table
// Drives request words in bursts, stalls the response side on its own
// pattern, reprograms the bucket count between phases and reports the result
// of the checker once every expected word has arrived.
// ----------------------------------------------------------------------------
module tb_top;
  import sght_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_cnt;
  int          pending;
  bit          long_stall;
  bit          drain_done;

  sght_in_if  req_if ();
  sght_out_if rsp_if ();

  spatial_grid_hash_table_top dut (
    .clk_i, .rst_ni, .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sght_checker chk (
    .clk_i, .rst_ni, .req_mon(req_if.sink), .rsp_mon(rsp_if.sink),
    .cfg_wr_i(psel && penable && pwrite && pready), .cfg_val_i(pwdata[10:0]),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Coordinates recently inserted, reused so that lookups and removes hit
  logic [47:0] key_pool [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  // Response side: random stalls, with one long hold-off on request
  initial begin
    int hold;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        hold = 0;
        while (hold < 400) begin
          rsp_if.ready <= 1'b0;
          @(posedge clk_i);
          hold++;
        end
        long_stall = 1'b0;
      end
      case ($urandom_range(0, 2))
        0: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        1: rsp_if.ready <= 1'b1;
        default: rsp_if.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // Write the bucket count through the register port
  task automatic write_bucket_count(logic [10:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(REG_BUCKET_COUNT) << 2;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one request word and hold it until accepted
  task automatic send_word(logic [1:0] mode, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, logic [15:0] hdl);
    req_if.valid       <= 1'b1;
    req_if.mode        <= mode;
    req_if.coord_x     <= x;
    req_if.coord_y     <= y;
    req_if.coord_z     <= z;
    req_if.cell_handle <= hdl;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (mode == MODE_INSERT) begin
      key_pool = {key_pool, {z, y, x}};
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
  endtask

  task automatic idle_gap(int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Random word: mostly reused keys, occasional full-range noise
  task automatic send_random();
    logic [47:0] k;
    logic [1:0]  mode;
    int          sel;
    sel  = $urandom_range(0, 9);
    mode = $urandom_range(0, 9) < 4 ? MODE_INSERT : 2'($urandom_range(1, 3));
    if (sel < 6 && key_pool.size() > 0)
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if (sel < 8)
      k = {16'($urandom_range(0, 15) - 8), 16'($urandom_range(0, 15) - 8),
           16'($urandom_range(0, 15) - 8)};
    else
      k = {16'($urandom), 16'($urandom), 16'($urandom)};
    send_word(mode, k[15:0], k[31:16], k[47:32], 16'($urandom));
  endtask

  // Wait for every expected word, then let the block settle
  task automatic drain();
    int guard;
    req_if.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  logic [10:0] bc_list [6] = '{11'd1, 11'd0, 11'd2047, 11'd3, 11'd1024, 11'd37};

  initial begin
    int burst;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_if.valid = 1'b0; req_if.mode = '0; req_if.coord_x = '0;
    req_if.coord_y = '0; req_if.coord_z = '0; req_if.cell_handle = '0;
    long_stall = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every mode, overflow, missing key, duplicates
    write_bucket_count(11'd1);
    send_word(MODE_LOOKUP, 16'h0, 16'h0, 16'h0, 16'hffff);
    send_word(MODE_REMOVE, 16'h7fff, 16'h8000, 16'h7fff, 16'h0);
    send_word(MODE_INSERT, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_word(MODE_INSERT, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_word(MODE_INSERT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h1234);
    send_word(MODE_INSERT, 16'h0001, 16'hffff, 16'h0000, 16'haaaa);
    send_word(MODE_INSERT, 16'h5555, 16'haaaa, 16'h5555, 16'h5555);
    send_word(MODE_LOOKUP, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0);
    send_word(2'd3, 16'h8000, 16'h8000, 16'h8000, 16'h0);
    send_word(MODE_REMOVE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0);
    send_word(MODE_LOOKUP, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0);
    send_word(MODE_LOOKUP, 16'h0001, 16'hffff, 16'h0000, 16'h0);
    send_word(MODE_REMOVE, 16'h8000, 16'h8000, 16'h8000, 16'h0);
    send_word(MODE_LOOKUP, 16'h1111, 16'h2222, 16'h3333, 16'h0);
    drain();

    // Random phases under several bucket counts
    foreach (bc_list[p]) begin
      write_bucket_count(bc_list[p]);
      for (int n = 0; n < 230;) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst && n < 230; j++, n++) send_random();
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 20));
        if (p == 2 && n > 100 && n < 110) long_stall = 1'b1;
      end
      drain();
    end

    // Words still owed count as a failure
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
